// ----- rtl/core/clgf_pkg.sv -----
// Shared types and constants of the client link gate.
package clgf_pkg;

	// Item opcodes
	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Result kinds
	localparam logic [3:0] KIND_CAP_TAKEN  = 4'd0;
	localparam logic [3:0] KIND_CAP_BAD    = 4'd1;
	localparam logic [3:0] KIND_REFUSED    = 4'd2;
	localparam logic [3:0] KIND_DATA_DROP  = 4'd3;
	localparam logic [3:0] KIND_PROXY      = 4'd4;
	localparam logic [3:0] KIND_QUEUED     = 4'd5;
	localparam logic [3:0] KIND_FULL_DROP  = 4'd6;
	localparam logic [3:0] KIND_DET_REJECT = 4'd7;
	localparam logic [3:0] KIND_IDLE       = 4'd8;
	localparam logic [3:0] KIND_TIMEOUT    = 4'd9;
	localparam logic [3:0] KIND_STATUS     = 4'd10;
	localparam logic [3:0] KIND_REPORT     = 4'd11;

	// Configuration register indexes
	localparam logic [2:0] REG_CAP_TYPE    = 3'd0;
	localparam logic [2:0] REG_DATA_TYPE   = 3'd1;
	localparam logic [2:0] REG_ALLOWED     = 3'd2;
	localparam logic [2:0] REG_TIMEOUT     = 3'd3;
	localparam logic [2:0] REG_PERIOD      = 3'd4;
	localparam logic [2:0] REG_FLAG        = 3'd5;

	// Configuration reset values
	localparam logic [7:0]  RST_CAP_TYPE  = 8'd0;
	localparam logic [7:0]  RST_DATA_TYPE = 8'd1;
	localparam logic [15:0] RST_ALLOWED   = 16'd0;
	localparam logic [31:0] RST_TIMEOUT   = 32'd5000;
	localparam logic [15:0] RST_PERIOD    = 16'd1000;
	localparam logic [7:0]  RST_FLAG      = 8'd126;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DRAIN
	} clgf_state_t;

	// Wrapping "a after b": difference positive as two's complement
	function automatic logic time_after(input logic [31:0] diff);
		time_after = (diff != 32'd0) && !diff[31];
	endfunction

endpackage

// ----- rtl/core/clgf_ring_mem.sv -----
// Byte ring storage: one write port, one registered read port.
module clgf_ring_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/client_link_gate_fifo.sv -----
// Top level of the client link gate: attach control, status timing and byte ring.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//  in      | in_valid/in_ready, opcode .. sink_ready   | in
//  out     | out_valid/out_ready, kind .. attached     | out
//
// Steps: an item is latched in ST_IDLE and decided in ST_DECIDE; a tick
// that drains a report then emits REPORT_BYTES bytes in ST_DRAIN, one byte
// per cycle while the output is not stalled, read from the ring memory's
// read port and padded with the flag byte once the ring is empty.
// Reset clears all control state and the ring pointers; the ring memory
// itself is not cleared (only written entries are ever read).
// A stalled output holds the decision or drain step; the input stays closed
// until the current item has handed its last result to the output register.
module client_link_gate_fifo #(
	parameter int RING_DEPTH   = 1024,
	parameter int REPORT_BYTES = 63
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] now,
	input  logic [7:0]  frame_type,
	input  logic        attach_ok,
	input  logic [15:0] announced_caps,
	input  logic [7:0]  out_byte,
	input  logic        sink_ready,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  kind,
	output logic [7:0]  report_byte,
	output logic        last,
	output logic [15:0] status_seq,
	output logic [15:0] effective_caps,
	output logic        attached
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(REPORT_BYTES + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REPORT_BYTES - 1);

	// Configuration registers
	logic [7:0]  cap_type_q, data_type_q, flag_q;
	logic [15:0] allowed_q, period_q;
	logic [31:0] timeout_q;

	// Link state
	clgf_pkg::clgf_state_t state_q, state_d;
	logic             attached_q;
	logic [15:0]      caps_q;
	logic [31:0]      heard_q;
	logic [31:0]      next_status_q;
	logic [15:0]      counter_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] k_q;

	// Latched item and precomputed time differences
	logic [1:0]  op_q;
	logic [31:0] now_q;
	logic [7:0]  ftype_q, byte_q;
	logic        ok_q, rdy_q;
	logic [15:0] ann_q;
	logic [31:0] deadline_q;
	logic [31:0] sdiff_q;

	// Output register
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [7:0]  rbyte_q;
	logic        last_q;
	logic [15:0] seq_q;
	logic [15:0] ecaps_q;
	logic        eatt_q;

	// Ring memory interface
	logic [7:0]       rd_data;
	logic [PTR_W-1:0] tail_d;

	// Decision signals
	logic             load_ok, in_acc;
	logic             ring_empty, ring_full, tmo_fire, status_due, drain_go;
	logic [PTR_W-1:0] head_inc, tail_inc;
	logic             emit, e_last;
	logic [3:0]       e_kind;
	logic [7:0]       e_byte;
	logic [15:0]      e_seq;
	logic             upd_heard, set_caps, do_attach, do_detach;
	logic             do_push, do_status, do_pop;
	logic             att_n;
	logic [15:0]      caps_n;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == clgf_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign load_ok   = !out_valid_q || out_ready;

	assign head_inc   = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign ring_empty = (head_q == tail_q);
	assign ring_full  = (head_inc == tail_q);

	// Timeout and status checks on the latched time
	assign tmo_fire   = attached_q && clgf_pkg::time_after(now_q - deadline_q);
	assign status_due = clgf_pkg::time_after(sdiff_q);
	assign drain_go   = !ring_empty && rdy_q;

	// Read the entry the tail will point at, so rd_data tracks the tail
	assign tail_d = do_detach ? '0 : (do_pop ? tail_inc : tail_q);

	clgf_ring_mem #(
		.DEPTH (RING_DEPTH),
		.AW    (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (head_q),
		.wr_data (byte_q),
		.rd_addr (tail_d),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clgf_pkg::ST_IDLE: begin
				if (in_acc) state_d = clgf_pkg::ST_DECIDE;
			end
			clgf_pkg::ST_DECIDE: begin
				if (load_ok) begin
					if (op_q == clgf_pkg::OP_TICK && !tmo_fire && attached_q && drain_go)
						state_d = clgf_pkg::ST_DRAIN;
					else
						state_d = clgf_pkg::ST_IDLE;
				end
			end
			clgf_pkg::ST_DRAIN: begin
				if (load_ok && k_q == CNT_LAST) state_d = clgf_pkg::ST_IDLE;
			end
			default: state_d = clgf_pkg::ST_IDLE;
		endcase
	end

	// Actions and result of the current step
	always_comb begin
		emit      = 1'b0;
		e_kind    = clgf_pkg::KIND_IDLE;
		e_byte    = 8'd0;
		e_seq     = 16'd0;
		e_last    = 1'b1;
		upd_heard = 1'b0;
		set_caps  = 1'b0;
		do_attach = 1'b0;
		do_detach = 1'b0;
		do_push   = 1'b0;
		do_status = 1'b0;
		do_pop    = 1'b0;
		unique case (state_q)
			clgf_pkg::ST_IDLE: ;
			clgf_pkg::ST_DECIDE: begin
				if (load_ok) begin
					case (op_q)
						clgf_pkg::OP_FRAME: begin
							emit      = 1'b1;
							upd_heard = 1'b1;
							if (ftype_q == cap_type_q) begin
								if (ok_q) begin
									set_caps  = 1'b1;
									do_attach = !attached_q;
									e_kind    = clgf_pkg::KIND_CAP_TAKEN;
								end else begin
									e_kind = clgf_pkg::KIND_CAP_BAD;
								end
							end else if (ftype_q != data_type_q) begin
								e_kind = clgf_pkg::KIND_REFUSED;
							end else if (!attached_q) begin
								e_kind = clgf_pkg::KIND_DATA_DROP;
							end else begin
								e_kind = clgf_pkg::KIND_PROXY;
							end
						end
						clgf_pkg::OP_BYTE: begin
							emit = 1'b1;
							if (!attached_q) begin
								e_kind = clgf_pkg::KIND_DET_REJECT;
							end else if (ring_full) begin
								e_kind = clgf_pkg::KIND_FULL_DROP;
							end else begin
								do_push = 1'b1;
								e_kind  = clgf_pkg::KIND_QUEUED;
							end
						end
						clgf_pkg::OP_TICK: begin
							if (tmo_fire) begin
								emit      = 1'b1;
								do_detach = 1'b1;
								e_kind    = clgf_pkg::KIND_TIMEOUT;
							end else if (attached_q) begin
								if (status_due) begin
									emit      = 1'b1;
									do_status = 1'b1;
									e_kind    = clgf_pkg::KIND_STATUS;
									e_seq     = counter_q;
									e_last    = !drain_go;
								end else if (!drain_go) begin
									emit = 1'b1;
								end
							end else begin
								emit = 1'b1;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			clgf_pkg::ST_DRAIN: begin
				if (load_ok) begin
					emit   = 1'b1;
					e_kind = clgf_pkg::KIND_REPORT;
					e_byte = ring_empty ? flag_q : rd_data;
					do_pop = !ring_empty;
					e_last = (k_q == CNT_LAST);
				end
			end
			default: ;
		endcase
	end

	// Link state as it stands after this step
	assign att_n  = do_detach ? 1'b0 : (do_attach ? 1'b1 : attached_q);
	assign caps_n = do_detach ? 16'd0 : (set_caps ? (ann_q & allowed_q) : caps_q);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_type_q    <= clgf_pkg::RST_CAP_TYPE;
			data_type_q   <= clgf_pkg::RST_DATA_TYPE;
			allowed_q     <= clgf_pkg::RST_ALLOWED;
			timeout_q     <= clgf_pkg::RST_TIMEOUT;
			period_q      <= clgf_pkg::RST_PERIOD;
			flag_q        <= clgf_pkg::RST_FLAG;
			state_q       <= clgf_pkg::ST_IDLE;
			attached_q    <= 1'b0;
			caps_q        <= 16'd0;
			heard_q       <= 32'd0;
			next_status_q <= 32'd0;
			counter_q     <= 16'd0;
			head_q        <= '0;
			tail_q        <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					clgf_pkg::REG_CAP_TYPE:  cap_type_q  <= cfg_data[7:0];
					clgf_pkg::REG_DATA_TYPE: data_type_q <= cfg_data[7:0];
					clgf_pkg::REG_ALLOWED:   allowed_q   <= cfg_data[15:0];
					clgf_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data;
					clgf_pkg::REG_PERIOD:    period_q    <= cfg_data[15:0];
					clgf_pkg::REG_FLAG:      flag_q      <= cfg_data[7:0];
					default: ;
				endcase
			end
			state_q    <= state_d;
			attached_q <= att_n;
			caps_q     <= caps_n;
			if (upd_heard) heard_q <= now_q;
			if (do_attach) begin
				next_status_q <= 32'd0;
			end else if (do_status) begin
				next_status_q <= now_q + {16'd0, period_q};
			end
			if (do_status) counter_q <= counter_q + 16'd1;
			if (do_detach) begin
				head_q <= '0;
			end else if (do_push) begin
				head_q <= head_inc;
			end
			tail_q <= tail_d;
			// restart the report count on every decision, advance per byte
			if (state_q == clgf_pkg::ST_DECIDE) begin
				k_q <= '0;
			end else if (state_q == clgf_pkg::ST_DRAIN && emit) begin
				k_q <= k_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item latch and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= opcode;
			now_q      <= now;
			ftype_q    <= frame_type;
			ok_q       <= attach_ok;
			ann_q      <= announced_caps;
			byte_q     <= out_byte;
			rdy_q      <= sink_ready;
			deadline_q <= heard_q + timeout_q;
			sdiff_q    <= now - next_status_q;
		end
		if (emit) begin
			kind_q  <= e_kind;
			rbyte_q <= e_byte;
			last_q  <= e_last;
			seq_q   <= e_seq;
			ecaps_q <= att_n ? caps_n : 16'd0;
			eatt_q  <= att_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign report_byte    = rbyte_q;
	assign last           = last_q;
	assign status_seq     = seq_q;
	assign effective_caps = ecaps_q;
	assign attached       = eatt_q;

	// A detached client never has queued bytes or stored caps
	a_detached_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!attached_q |-> (head_q == tail_q) && (caps_q == 16'd0))
		else $error("detached client with queued bytes or caps");

	// A report drain only runs for an attached client
	a_drain_attached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clgf_pkg::ST_DRAIN) |-> attached_q)
		else $error("report drain while detached");

	// The final report byte closes the item and returns to idle
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clgf_pkg::ST_DRAIN && emit && e_last) |=> (state_q == clgf_pkg::ST_IDLE))
		else $error("drain did not finish after last byte");

	// Every decided item loads a result unless it moves on to a drain
	a_decide_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clgf_pkg::ST_DECIDE && load_ok && state_d == clgf_pkg::ST_IDLE) |-> emit)
		else $error("item finished without a result");

endmodule
